@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bilinear image sampler
// field widths, codes, default parameters and the control bundle of the
// shared multiply-accumulate unit
// ----------------------------------------------------------------------------
package bis_pkg;

  // fixed field widths
  localparam int COL_BITS   = 8;
  localparam int PIX_IN_BITS = 16;
  localparam int COORD_BITS = 16;
  localparam int VALUE_BITS = 16;
  localparam int CFG_BITS   = 9;

  // default module parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_FRAC_BITS  = 8;

  // dimension registers after reset
  localparam logic [CFG_BITS-1:0] DIM_RESET = 9'd256;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;   // load product register
    logic acc_en;   // update accumulator
    logic acc_clr;  // accumulator starts from the product alone
  } mac_ctrl_t;

  function automatic int bis_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/bis_in_if.sv @@
// ----------------------------------------------------------------------------
// bis_in_if: input channel of the bilinear image sampler
// valid/ready handshake carrying one write or sample request per beat
// ----------------------------------------------------------------------------
interface bis_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic [bis_pkg::COL_BITS-1:0]           write_col;
  logic [bis_pkg::COL_BITS-1:0]           write_row;
  logic signed [bis_pkg::PIX_IN_BITS-1:0] pixel_value;
  logic [bis_pkg::COORD_BITS-1:0]         point_x;
  logic [bis_pkg::COORD_BITS-1:0]         point_y;

  modport source (
    output valid, mode, write_col, write_row, pixel_value, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, mode, write_col, write_row, pixel_value, point_x, point_y,
    output ready
  );
endinterface

@@ rtl/bis_out_if.sv @@
// ----------------------------------------------------------------------------
// bis_out_if: result channel of the bilinear image sampler
// valid/ready handshake carrying one result per beat
// ----------------------------------------------------------------------------
interface bis_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bis_pkg::VALUE_BITS-1:0] sample_value;
  logic                                  out_of_bounds;

  modport source (
    output valid, sample_value, out_of_bounds,
    input  ready
  );

  modport sink (
    input  valid, sample_value, out_of_bounds,
    output ready
  );
endinterface

@@ rtl/bis_pixel_mem.sv @@
// ----------------------------------------------------------------------------
// bis_pixel_mem: single-port pixel store
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module bis_pixel_mem #(
  parameter int DEPTH = bis_pkg::DEF_MAX_WIDTH * bis_pkg::DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = bis_pkg::DEF_PIXEL_BITS
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        addr_i,
  input  logic signed [DW-1:0] wdata_i,
  output logic signed [DW-1:0] rdata_o
);

  logic signed [DW-1:0] mem_q [DEPTH];
  logic signed [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bis_mac.sv @@
// ----------------------------------------------------------------------------
// bis_mac: shared multiply-accumulate unit
// signed by unsigned product into a register, accumulated from that register later
// ----------------------------------------------------------------------------
module bis_mac #(
  parameter int A_W   = 18,
  parameter int B_W   = 17,
  parameter int ACC_W = 33,
  parameter int PROD_W = A_W + B_W + 1
) (
  input  logic                     clk_i,
  input  bis_pkg::mac_ctrl_t       ctrl_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic [B_W-1:0]           b_i,
  output logic signed [PROD_W-1:0] prod_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [B_W:0]      b_ext;

  assign b_ext = $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_ext;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= (ctrl_i.acc_clr ? '0 : acc_q) + ACC_W'(prod_q);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

@@ rtl/bilinear_image_sampler.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_sampler: pixel store with bilinear sampling
// write beats store one pixel, sample beats blend four neighbours
// ----------------------------------------------------------------------------
// A write beat runs the base, latch and store steps; a sample beat runs the
// base and latch steps, then the neighbour steps. The finish state loads the
// result into an output register, so the next beat is accepted while it
// waits. One shared multiplier computes the row base address (width times
// row), then for each neighbour its weight and the weighted pixel, with the
// accumulator adding the previous one; the single port pixel store serves
// one neighbour read per even step. Neighbours outside the configured width
// and height contribute zero and are not read. The store has no reset; a
// pixel must be written before it is sampled. The user must write dimension
// registers only while the block is idle; the block does not enforce it.
module bilinear_image_sampler #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = bis_pkg::DEF_PIXEL_BITS,
  parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [bis_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  bis_in_if.sink                         in_i,
  bis_out_if.source                      out_o
);

  // derived sizes
  localparam int WC     = $clog2(MAX_WIDTH + 1);
  localparam int HC     = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = bis_pkg::COORD_BITS + 1;
  localparam int A_W    = bis_pkg::bis_max(PIXEL_BITS, CW + 1);
  localparam int B_W    = bis_pkg::bis_max(2 * FRAC_BITS + 1, WC);
  localparam int PROD_W = A_W + B_W + 1;
  localparam int SHIFT  = 2 * FRAC_BITS;
  localparam int ACC_W  = PIXEL_BITS + SHIFT + 1;
  localparam int Q_W    = ACC_W - SHIFT;

  // sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_MUL_BASE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LATCH     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_STORE     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FIRST_RD  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FIRST_ACC = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LAST_RD   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LAST      = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SAMPLE,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    ASEL_COORD,
    ASEL_WEIGHT,
    ASEL_PIXEL
  } a_sel_e;

  typedef enum logic [1:0] {
    BSEL_WIDTH,
    BSEL_WEIGHT,
    BSEL_PROD
  } b_sel_e;

  // configuration
  logic [bis_pkg::CFG_BITS-1:0] image_width_q;
  logic [bis_pkg::CFG_BITS-1:0] image_height_q;
  logic [WC-1:0]                w_eff;
  logic [HC-1:0]                h_eff;

  // item state
  state_e                       state_q;
  logic [STEP_W-1:0]            step_q;
  logic                         mode_q;
  logic [CW-1:0]                x_q;
  logic [CW-1:0]                y_q;
  logic [FRAC_BITS-1:0]         xp_q;
  logic [FRAC_BITS-1:0]         yp_q;
  logic signed [PIXEL_BITS-1:0] pix_wr_q;
  logic [AW-1:0]                base_q;
  logic                         nval_q;
  logic                         oob_q;

  // result register
  logic                                  out_valid_q;
  logic signed [bis_pkg::VALUE_BITS-1:0] out_value_q;
  logic                                  out_oob_q;

  // neighbour addressing
  logic [1:0]           nb_sel;
  logic [CW-1:0]        nb_col;
  logic [CW-1:0]        nb_row;
  logic                 nb_ok;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic                 mem_re;
  logic signed [PIXEL_BITS-1:0] mem_rdata;
  logic signed [PIXEL_BITS-1:0] pix_rd;

  // arithmetic
  logic [FRAC_BITS:0]       xm;
  logic [FRAC_BITS:0]       ym;
  logic [FRAC_BITS:0]       xw;
  logic [FRAC_BITS:0]       yw;
  a_sel_e                   a_sel;
  b_sel_e                   b_sel;
  bis_pkg::mac_ctrl_t       mac_ctrl;
  logic signed [A_W-1:0]    mul_a;
  logic [B_W-1:0]           mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [Q_W-1:0]    quo;
  logic                     finish_load;
  logic                     in_beat;
  logic                     is_sample;
  logic                     is_write;

  // oversized dimensions clamp to the store size
  assign w_eff = (int'(image_width_q) > MAX_WIDTH) ? WC'(MAX_WIDTH) : WC'(image_width_q);
  assign h_eff = (int'(image_height_q) > MAX_HEIGHT) ? HC'(MAX_HEIGHT) : HC'(image_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= bis_pkg::DIM_RESET;
      image_height_q <= bis_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bis_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i;
        bis_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign is_sample  = (state_q == ST_SAMPLE);
  assign is_write   = (state_q == ST_WRITE);

  // neighbour k: bit 0 steps one column right, bit 1 one row down;
  // read steps 2,4,6,8 visit neighbours 0..3, weight 0 is formed at step 1
  assign nb_sel = (is_sample && step_q >= STEP_FIRST_RD) ? 2'(step_q[3:1] - 3'd1) : 2'd0;
  assign nb_col = x_q + CW'(nb_sel[0]);
  assign nb_row = y_q + CW'(nb_sel[1]);
  assign nb_ok  = (nb_col < CW'(w_eff)) && (nb_row < CW'(h_eff));

  // row-major address: row base plus one width for the lower row plus column
  assign mem_addr = base_q + (nb_sel[1] ? AW'(w_eff) : AW'(0)) + AW'(nb_col);

  assign mem_we = is_write && (step_q == STEP_STORE) && nb_ok;
  assign mem_re = is_sample && !step_q[0] && (step_q >= STEP_FIRST_RD)
                  && (step_q <= STEP_LAST_RD) && nb_ok;

  // fractional weights
  assign xm = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, xp_q};
  assign ym = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, yp_q};
  assign xw = nb_sel[0] ? {1'b0, xp_q} : xm;
  assign yw = nb_sel[1] ? {1'b0, yp_q} : ym;

  assign pix_rd = nval_q ? mem_rdata : '0;

  // shared unit schedule:
  //   step 0      width times row
  //   step 1      first weight
  //   odd steps   weighted pixel from the weight in the product register
  //   even steps  from step 4 accumulate the previous weighted pixel, next weight but at the last
  always_comb begin
    mac_ctrl = '0;
    a_sel    = ASEL_WEIGHT;
    b_sel    = BSEL_WEIGHT;
    if (step_q == STEP_MUL_BASE) begin
      mac_ctrl.mul_en = is_write || is_sample;
      a_sel           = ASEL_COORD;
      b_sel           = BSEL_WIDTH;
    end else if (is_sample) begin
      if (step_q[0]) begin
        mac_ctrl.mul_en = 1'b1;
        if (step_q != STEP_LATCH) begin
          a_sel = ASEL_PIXEL;
          b_sel = BSEL_PROD;
        end
      end else if (step_q >= STEP_FIRST_ACC) begin
        mac_ctrl.acc_en  = 1'b1;
        mac_ctrl.acc_clr = (step_q == STEP_FIRST_ACC);
        mac_ctrl.mul_en  = (step_q != STEP_LAST);
      end
    end
  end

  always_comb begin
    unique case (a_sel)
      ASEL_COORD:  mul_a = A_W'(y_q);
      ASEL_WEIGHT: mul_a = A_W'(xw);
      ASEL_PIXEL:  mul_a = A_W'(pix_rd);
      default:     mul_a = '0;
    endcase
    unique case (b_sel)
      BSEL_WIDTH:  mul_b = B_W'(w_eff);
      BSEL_WEIGHT: mul_b = B_W'(yw);
      BSEL_PROD:   mul_b = B_W'(prod);
      default:     mul_b = '0;
    endcase
  end

  bis_mac #(
    .A_W   (A_W),
    .B_W   (B_W),
    .ACC_W (ACC_W),
    .PROD_W(PROD_W)
  ) u_mac (
    .clk_i (clk_i),
    .ctrl_i(mac_ctrl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod),
    .acc_o (acc)
  );

  bis_pixel_mem #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (PIXEL_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(pix_wr_q),
    .rdata_o(mem_rdata)
  );

  // divide by the weight scale, truncating toward zero
  assign acc_adj = acc + $signed({{Q_W{1'b0}}, {SHIFT{acc[ACC_W-1]}}});
  assign quo     = acc_adj[ACC_W-1:SHIFT];

  assign finish_load = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_MUL_BASE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            step_q   <= STEP_MUL_BASE;
            mode_q   <= in_i.mode;
            pix_wr_q <= PIXEL_BITS'(in_i.pixel_value);
            if (in_i.mode == bis_pkg::MODE_SAMPLE) begin
              state_q <= ST_SAMPLE;
              x_q     <= CW'(in_i.point_x >> FRAC_BITS);
              y_q     <= CW'(in_i.point_y >> FRAC_BITS);
              xp_q    <= in_i.point_x[FRAC_BITS-1:0];
              yp_q    <= in_i.point_y[FRAC_BITS-1:0];
            end else begin
              state_q <= ST_WRITE;
              x_q     <= CW'(in_i.write_col);
              y_q     <= CW'(in_i.write_row);
            end
          end
        end
        ST_WRITE: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LATCH) begin
            base_q <= AW'(prod);
          end
          if (step_q == STEP_STORE) begin
            oob_q   <= !nb_ok;
            state_q <= ST_FINISH;
          end
        end
        ST_SAMPLE: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LATCH) begin
            base_q <= AW'(prod);
          end
          if (!step_q[0] && step_q >= STEP_FIRST_RD && step_q <= STEP_LAST_RD) begin
            nval_q <= nb_ok;
          end
          if (step_q == STEP_LAST) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // result register parts the sequencer from the sink
      if (finish_load) begin
        out_valid_q <= 1'b1;
        if (mode_q == bis_pkg::MODE_SAMPLE) begin
          out_value_q <= bis_pkg::VALUE_BITS'(quo);
          out_oob_q   <= 1'b0;
        end else begin
          out_value_q <= '0;
          out_oob_q   <= oob_q;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_value  = out_value_q;
  assign out_o.out_of_bounds = out_oob_q;

  // the single store port never reads and writes in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && mem_re))
    else $error("pixel store read and write in the same cycle");

  // a result only appears from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result offered outside finish");

  // a dropped write never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oob_q |-> out_value_q == '0)
    else $error("out-of-bounds result with nonzero value");

  // handing a result over frees the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_load |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("finish did not hand over the result");

  // every accepted beat starts at the base address step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (step_q == STEP_MUL_BASE) && (state_q != ST_IDLE))
    else $error("accepted beat did not start the sequence");

endmodule
